@@ hw/rtl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the Go-Back-N sender window.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

    localparam int WINDOW_DEF = 4;

    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] payload;
        logic [15:0] ack_number;
        logic        ack_check_ok;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        pkt_valid;
        logic [15:0] pkt_seq;
        logic [31:0] pkt_payload;
        logic        last;
        logic [1:0]  timer_cmd;
        logic [15:0] timer_seq;
        logic        window_full;
        logic [6:0]  window_count;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbn_buf.sv @@
// ----------------------------------------------------------------------------
// gbn_buf
// Payload store of the window: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_buf #(
    parameter int DEPTH  = gbn_pkg::WINDOW_DEF,
    parameter int ADDR_W = 2
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [31:0]       rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/go_back_n_sender_window.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Send: result registered in the cycle after the beat is taken. Ack: the same.
// Timeout with N held packets: N result beats, the first via the store read
// and output registers, then one per cycle unless the output stalls, paced
// by the single store read port. No new request is taken during a replay.
// Reset sets the sequence numbers to 1 and clears counters and handshakes;
// the store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_window #(
    parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire gbn_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output gbn_pkg::rsp_t      rsp
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = CNT_W + 1;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPLAY = 1'b1;

    logic              state_reg, state_next;
    logic [15:0]       base_reg, base_next;
    logic [15:0]       nseq_reg, nseq_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  ridx_reg, ridx_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [15:0]       rseq_reg, rseq_next;
    logic              rsp_valid_reg, rsp_valid_next;
    gbn_pkg::rsp_t     rsp_reg, rsp_next;

    logic              out_free;
    logic              take;
    logic              wr_en, rd_en;
    logic [SLOT_W-1:0] wr_addr, rd_addr;
    logic [31:0]       rd_data;
    logic [SUM_W-1:0]  wsum, asum;
    logic [SLOT_W-1:0] wslot, aslot, rslot_inc;
    logic [15:0]       d;
    logic              ack_ok;
    logic [CNT_W-1:0]  num;
    logic [CNT_W-1:0]  held_after_ack;
    logic              rlast;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign take      = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // slot arithmetic modulo WINDOW, sums stay below 2*WINDOW
    assign wsum  = SUM_W'(oldest_reg) + SUM_W'(held_reg);
    assign wslot = (wsum >= SUM_W'(WINDOW)) ? SLOT_W'(wsum - SUM_W'(WINDOW)) : SLOT_W'(wsum);

    assign d      = req.ack_number - base_reg;
    assign ack_ok = (held_reg != '0) && req.ack_check_ok && (d < 16'(held_reg));
    assign num    = CNT_W'(d) + CNT_W'(1);
    assign held_after_ack = held_reg - num;
    assign asum  = SUM_W'(oldest_reg) + SUM_W'(num);
    assign aslot = (asum >= SUM_W'(WINDOW)) ? SLOT_W'(asum - SUM_W'(WINDOW)) : SLOT_W'(asum);

    assign rslot_inc = (rslot_reg == SLOT_W'(WINDOW - 1)) ? '0 : rslot_reg + SLOT_W'(1);
    assign rlast     = (ridx_reg + CNT_W'(1)) == held_reg;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        nseq_next      = nseq_reg;
        held_next      = held_reg;
        oldest_next    = oldest_reg;
        ridx_next      = ridx_reg;
        rslot_next     = rslot_reg;
        rseq_next      = rseq_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = wslot;
        rd_en          = 1'b0;
        rd_addr        = oldest_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    rsp_next              = '0;
                    rsp_next.last         = 1'b1;
                    rsp_next.window_full  = (held_reg == CNT_W'(WINDOW));
                    rsp_next.window_count = 7'(held_reg);
                    rsp_valid_next        = 1'b1;
                    unique case (req.op)
                        gbn_pkg::OP_SEND:
                        begin
                            if (held_reg != CNT_W'(WINDOW))
                            begin
                                wr_en                 = 1'b1;
                                held_next             = held_reg + CNT_W'(1);
                                nseq_next             = nseq_reg + 16'd1;
                                rsp_next.accepted     = 1'b1;
                                rsp_next.pkt_valid    = 1'b1;
                                rsp_next.pkt_seq      = nseq_reg;
                                rsp_next.pkt_payload  = req.payload;
                                rsp_next.window_full  = (held_next == CNT_W'(WINDOW));
                                rsp_next.window_count = 7'(held_next);
                                if (held_reg == '0)
                                begin
                                    rsp_next.timer_cmd = gbn_pkg::TMR_START;
                                    rsp_next.timer_seq = nseq_reg;
                                end
                            end
                        end
                        gbn_pkg::OP_ACK:
                        begin
                            if (ack_ok)
                            begin
                                base_next             = req.ack_number + 16'd1;
                                held_next             = held_after_ack;
                                oldest_next           = aslot;
                                rsp_next.window_full  = (held_after_ack == CNT_W'(WINDOW));
                                rsp_next.window_count = 7'(held_after_ack);
                                if (held_after_ack == '0)
                                begin
                                    rsp_next.timer_cmd = gbn_pkg::TMR_STOP;
                                    rsp_next.timer_seq = base_reg;
                                end
                                else
                                begin
                                    rsp_next.timer_cmd = gbn_pkg::TMR_RESTART;
                                    rsp_next.timer_seq = base_next;
                                end
                            end
                        end
                        gbn_pkg::OP_TIMEOUT:
                        begin
                            if (held_reg != '0)
                            begin
                                rsp_next       = rsp_reg;
                                rsp_valid_next = 1'b0;
                                rd_en          = 1'b1;
                                rd_addr        = oldest_reg;
                                ridx_next      = '0;
                                rslot_next     = oldest_reg;
                                rseq_next      = base_reg;
                                state_next     = ST_REPLAY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REPLAY:
            begin
                if (out_free)
                begin
                    rsp_next              = '0;
                    rsp_next.pkt_valid    = 1'b1;
                    rsp_next.pkt_seq      = rseq_reg;
                    rsp_next.pkt_payload  = rd_data;
                    rsp_next.last         = rlast;
                    rsp_next.window_full  = (held_reg == CNT_W'(WINDOW));
                    rsp_next.window_count = 7'(held_reg);
                    if (ridx_reg == '0)
                    begin
                        rsp_next.timer_cmd = gbn_pkg::TMR_RESTART;
                        rsp_next.timer_seq = base_reg;
                    end
                    rsp_valid_next = 1'b1;
                    ridx_next      = ridx_reg + CNT_W'(1);
                    rseq_next      = rseq_reg + 16'd1;
                    rslot_next     = rslot_inc;
                    if (rlast)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rslot_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= 16'd1;
            nseq_reg      <= 16'd1;
            held_reg      <= '0;
            oldest_reg    <= '0;
            ridx_reg      <= '0;
            rslot_reg     <= '0;
            rseq_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            nseq_reg      <= nseq_next;
            held_reg      <= held_next;
            oldest_reg    <= oldest_next;
            ridx_reg      <= ridx_next;
            rslot_reg     <= rslot_next;
            rseq_reg      <= rseq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    gbn_buf #(
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.payload),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire
